// File: rtl/lbdh_pkg.sv
// Package for the log bucket duration histogram unit.
// Types, codes and constants shared by the divider and the top level.
package lbdh_pkg;
    localparam int CLASSES = 5;
    localparam int DUR_W = 48;
    localparam int CNT_W = 32;
    localparam int TOT_W = 63;
    localparam int WID_W = 32;

    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        REG_IDLE_WIDTH    = 1'b0,
        REG_SUSPEND_WIDTH = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic [2:0] CLASS_SUSPEND = 3'd4;
endpackage

// File: rtl/lbdh_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses lbdh_pkg widths only.
module lbdh_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [lbdh_pkg::DUR_W-1:0] dividend,
    input  logic [lbdh_pkg::WID_W-1:0] divisor,
    output logic                       done,
    output logic [lbdh_pkg::DUR_W-1:0] quotient
);
    localparam int CW = $clog2(lbdh_pkg::DUR_W + 1);

    logic [lbdh_pkg::DUR_W-1:0] q_reg;
    logic [lbdh_pkg::WID_W:0]   r_reg;
    logic [lbdh_pkg::WID_W-1:0] d_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [lbdh_pkg::WID_W:0]   shifted;
    logic [lbdh_pkg::WID_W:0]   diff;

    always_comb
    begin
        shifted = {r_reg[lbdh_pkg::WID_W-1:0], q_reg[lbdh_pkg::DUR_W-1]};
        diff = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(lbdh_pkg::DUR_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= (divisor == '0) ? lbdh_pkg::WID_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            if (!diff[lbdh_pkg::WID_W])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[lbdh_pkg::DUR_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[lbdh_pkg::DUR_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

// File: rtl/log_bucket_duration_histogram_unit.sv
// Top level of the log bucket duration histogram unit.
// Depends on lbdh_pkg and lbdh_divider.
//
// Usage: an item is taken when start is high and busy is low. Every item
// gives one result beat, shown for one cycle with done high; the receiver
// cannot stall it.
// A record divides duration by the class's first-bucket width in the
// bit-serial divider, reads the bucket and class memories, writes back
// and presents the result.
// A read goes through the read and output states, as do mode three and a
// class above four. A clear sweeps the bucket memory one row per cycle.
// Reset also starts that clearing sweep, with busy
// high; configuration writes are taken at any time.
// cfg_we, cfg_index and cfg_data write the two width registers.
// Items are processed one at a time; busy stays high until the result.
module log_bucket_duration_histogram_unit
#(
    parameter int BUCKETS = 10,
    parameter int BUCKET_SHIFT = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  mode,
    input  logic [2:0]  stat_class,
    input  logic [47:0] duration,
    input  logic [3:0]  bucket_select,
    output logic [3:0]  bucket_index,
    output logic [31:0] bucket_hits,
    output logic [47:0] bucket_min,
    output logic [47:0] bucket_max,
    output logic [31:0] event_count,
    output logic [62:0] class_total
);
    localparam int ROW_W = lbdh_pkg::CNT_W + 2 * lbdh_pkg::DUR_W;
    localparam int LANES_W = ROW_W * lbdh_pkg::CLASSES;
    localparam int BW = $clog2(BUCKETS);
    localparam int LIM = BUCKET_SHIFT * (BUCKETS - 1);
    localparam int FW = 6;
    localparam logic [lbdh_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [lbdh_pkg::TOT_W-1:0] TOT_MAX = '1;

    // bucket memory: one row per bucket, all classes side by side
    logic [LANES_W-1:0] bmem [BUCKETS];
    logic [lbdh_pkg::CNT_W+lbdh_pkg::TOT_W-1:0] cmem [lbdh_pkg::CLASSES];

    lbdh_pkg::state_t state_reg, state_next;
    logic [31:0] idle_w_reg, susp_w_reg;
    logic [BW-1:0] sweep_reg;
    logic [1:0]  mode_reg;
    logic [2:0]  cls_reg;
    logic [47:0] dur_reg;
    logic [BW-1:0] bkt_reg;
    logic [LANES_W-1:0] brow_reg;
    logic [lbdh_pkg::CNT_W+lbdh_pkg::TOT_W-1:0] crow_reg;
    logic [3:0]  o_idx_reg;
    logic [31:0] o_hits_reg, o_cnt_reg;
    logic [47:0] o_min_reg, o_max_reg;
    logic [62:0] o_tot_reg;
    logic        done_reg;
    logic        go_reg;

    logic        div_done;
    logic [47:0] quot;
    logic [FW-1:0] fls;
    logic [BW-1:0] pick;
    logic [2:0]  cls_c;

    lbdh_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .dividend (dur_reg),
        .divisor  ((cls_reg == lbdh_pkg::CLASS_SUSPEND) ? susp_w_reg : idle_w_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        fls = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (quot[i])
            begin
                fls = FW'(i + 1);
            end
        end
        pick = '0;
        if (LIM < 48 && (quot >> LIM) != '0)
        begin
            pick = BW'(BUCKETS - 1);
        end
        else
        begin
            // ceil(fls / BUCKET_SHIFT) by threshold count
            for (int k = 1; k < BUCKETS; k++)
            begin
                if (int'(fls) > BUCKET_SHIFT * (k - 1))
                begin
                    pick = BW'(k);
                end
            end
        end
    end

    // update of the selected class lane
    logic [ROW_W-1:0] lane, lane_new;
    logic [31:0] h_old, h_new;
    logic [47:0] mn_old, mx_old, mn_new, mx_new;
    logic [31:0] c_old, c_new;
    logic [62:0] t_old, t_new;
    logic [63:0] t_sum;
    logic [LANES_W-1:0] brow_new;

    always_comb
    begin
        cls_c = (cls_reg < 3'(lbdh_pkg::CLASSES)) ? cls_reg : 3'd0;
        lane = brow_reg[cls_c * ROW_W +: ROW_W];
        {h_old, mn_old, mx_old} = lane;
        {c_old, t_old} = crow_reg;
        h_new = (h_old == CNT_MAX) ? h_old : h_old + 1'b1;
        c_new = (c_old == CNT_MAX) ? c_old : c_old + 1'b1;
        t_sum = {1'b0, t_old} + {16'd0, dur_reg};
        t_new = t_sum[63] ? TOT_MAX : t_sum[62:0];
        mn_new = (h_old == '0 || dur_reg < mn_old) ? dur_reg : mn_old;
        mx_new = (h_old == '0 || dur_reg > mx_old) ? dur_reg : mx_old;
        lane_new = {h_new, mn_new, mx_new};
        brow_new = brow_reg;
        brow_new[cls_c * ROW_W +: ROW_W] = lane_new;
    end

    always_comb
    begin
        state_next = state_reg;
        busy = 1'b1;
        unique case (state_reg)
            lbdh_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (mode == lbdh_pkg::MODE_CLEAR)
                    begin
                        state_next = lbdh_pkg::ST_CLEAR;
                    end
                    else if (mode == lbdh_pkg::MODE_RECORD &&
                             stat_class < 3'(lbdh_pkg::CLASSES))
                    begin
                        state_next = lbdh_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = lbdh_pkg::ST_READ;
                    end
                end
            end
            lbdh_pkg::ST_CLEAR:
            begin
                // the sweep after reset gives no beat
                if (sweep_reg == BW'(BUCKETS - 1))
                begin
                    state_next = (mode_reg == lbdh_pkg::MODE_CLEAR) ?
                                 lbdh_pkg::ST_OUT : lbdh_pkg::ST_IDLE;
                end
            end
            lbdh_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = lbdh_pkg::ST_READ;
                end
            end
            lbdh_pkg::ST_READ:
            begin
                state_next = (mode_reg == lbdh_pkg::MODE_RECORD &&
                              cls_reg < 3'(lbdh_pkg::CLASSES)) ?
                             lbdh_pkg::ST_UPDATE : lbdh_pkg::ST_OUT;
            end
            lbdh_pkg::ST_UPDATE:
            begin
                state_next = lbdh_pkg::ST_IDLE;
            end
            lbdh_pkg::ST_OUT:
            begin
                state_next = lbdh_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lbdh_pkg::ST_IDLE;
            end
        endcase
    end

    // divider starts the cycle after acceptance, once operands are latched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbdh_pkg::ST_CLEAR;
            sweep_reg <= '0;
            idle_w_reg <= 32'd62500;
            susp_w_reg <= 32'd1000000000;
            done_reg <= 1'b0;
            go_reg <= 1'b0;
            mode_reg <= lbdh_pkg::MODE_NONE;
        end
        else
        begin
            state_reg <= state_next;
            go_reg <= (state_reg == lbdh_pkg::ST_IDLE) && start &&
                      (state_next == lbdh_pkg::ST_DIV);
            done_reg <= (state_reg == lbdh_pkg::ST_UPDATE) ||
                        (state_reg == lbdh_pkg::ST_OUT);
            if (state_reg == lbdh_pkg::ST_CLEAR)
            begin
                sweep_reg <= (sweep_reg == BW'(BUCKETS - 1)) ? '0 : sweep_reg + 1'b1;
            end
            if (cfg_we)
            begin
                if (cfg_index == lbdh_pkg::REG_IDLE_WIDTH)
                begin
                    idle_w_reg <= cfg_data;
                end
                else
                begin
                    susp_w_reg <= cfg_data;
                end
            end
            if (state_reg == lbdh_pkg::ST_IDLE && start)
            begin
                mode_reg <= mode;
            end
            else if (state_reg == lbdh_pkg::ST_OUT)
            begin
                mode_reg <= lbdh_pkg::MODE_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lbdh_pkg::ST_IDLE && start)
        begin
            cls_reg <= stat_class;
            dur_reg <= duration;
            bkt_reg <= ({1'b0, bucket_select} >= 5'(BUCKETS)) ? BW'(BUCKETS - 1)
                                                               : bucket_select[BW-1:0];
        end
        if (state_reg == lbdh_pkg::ST_DIV && div_done)
        begin
            bkt_reg <= pick;
        end
        brow_reg <= bmem[bkt_reg];
        crow_reg <= cmem[cls_c];
        if (state_reg == lbdh_pkg::ST_CLEAR)
        begin
            bmem[sweep_reg] <= '0;
            for (int i = 0; i < lbdh_pkg::CLASSES; i++)
            begin
                cmem[i] <= '0;
            end
        end
        else if (state_reg == lbdh_pkg::ST_UPDATE)
        begin
            bmem[bkt_reg] <= brow_new;
            cmem[cls_c] <= {c_new, t_new};
        end
        if (state_reg == lbdh_pkg::ST_UPDATE)
        begin
            o_idx_reg <= 4'(bkt_reg);
            {o_hits_reg, o_min_reg, o_max_reg} <= lane_new;
            o_cnt_reg <= c_new;
            o_tot_reg <= t_new;
        end
        else if (state_reg == lbdh_pkg::ST_OUT)
        begin
            if (mode_reg == lbdh_pkg::MODE_READ && cls_reg < 3'(lbdh_pkg::CLASSES))
            begin
                o_idx_reg <= 4'(bkt_reg);
                {o_hits_reg, o_min_reg, o_max_reg} <= lane;
                {o_cnt_reg, o_tot_reg} <= crow_reg;
            end
            else
            begin
                o_idx_reg <= '0;
                o_hits_reg <= '0;
                o_min_reg <= '0;
                o_max_reg <= '0;
                o_cnt_reg <= '0;
                o_tot_reg <= '0;
            end
        end
    end

    assign done = done_reg;
    assign bucket_index = o_idx_reg;
    assign bucket_hits = o_hits_reg;
    assign bucket_min = o_min_reg;
    assign bucket_max = o_max_reg;
    assign event_count = o_cnt_reg;
    assign class_total = o_tot_reg;
endmodule

// File: tb/log_bucket_duration_histogram_unit_test.sv
// Self-checking testbench for log_bucket_duration_histogram_unit.
// Drives record, clear and read commands and invalid modes and classes, predicts each result beat in-line.
// Depends on lbdh_pkg and the RTL top level.
`timescale 1ns / 100ps

module log_bucket_duration_histogram_unit_test;
    localparam int BUCKETS = 10;
    localparam int BSHIFT = 2;
    localparam int NBINS = lbdh_pkg::CLASSES * BUCKETS;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;
    localparam logic [62:0] TOT_SAT = {63{1'b1}};
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [3:0]  bidx;
        logic [31:0] hits;
        logic [47:0] dmin;
        logic [47:0] dmax;
        logic [31:0] evts;
        logic [62:0] total;
    } hist_beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic [1:0]  mode;
    logic [2:0]  stat_class;
    logic [47:0] duration;
    logic [3:0]  bucket_select;
    logic [3:0]  bucket_index;
    logic [31:0] bucket_hits;
    logic [47:0] bucket_min;
    logic [47:0] bucket_max;
    logic [31:0] event_count;
    logic [62:0] class_total;

    logic [31:0] idle_width;
    logic [31:0] susp_width;
    logic [31:0] bin_hits [NBINS];
    logic [47:0] bin_min [NBINS];
    logic [47:0] bin_max [NBINS];
    logic [31:0] cls_events [lbdh_pkg::CLASSES];
    logic [62:0] cls_total [lbdh_pkg::CLASSES];

    hist_beat_t  pending_beats[$];
    int          errors;
    int          beats_checked;
    int          idle_cycles;
    bit          no_gaps;

    log_bucket_duration_histogram_unit #(.BUCKETS(BUCKETS), .BUCKET_SHIFT(BSHIFT)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mode(mode), .stat_class(stat_class), .duration(duration),
        .bucket_select(bucket_select), .bucket_index(bucket_index),
        .bucket_hits(bucket_hits), .bucket_min(bucket_min), .bucket_max(bucket_max),
        .event_count(event_count), .class_total(class_total)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int bucket_of(logic [47:0] q);
        int fls;
        fls = 0;
        if (q >= (48'd1 << (BSHIFT * (BUCKETS - 1))))
            return BUCKETS - 1;
        for (int i = 0; i < 48; i++)
            if (q[i])
                fls = i + 1;
        return (fls + BSHIFT - 1) / BSHIFT;
    endfunction

    function automatic hist_beat_t histogram_step(lbdh_pkg::mode_t m, logic [2:0] c,
                                                  logic [47:0] d, logic [3:0] sel);
        hist_beat_t r;
        logic [31:0] w;
        logic [47:0] q;
        logic [63:0] sum;
        int b, k;
        r = '0;
        if (m == lbdh_pkg::MODE_CLEAR)
        begin
            for (int i = 0; i < NBINS; i++)
            begin
                bin_hits[i] = '0;
                bin_min[i] = '0;
                bin_max[i] = '0;
            end
            for (int i = 0; i < lbdh_pkg::CLASSES; i++)
            begin
                cls_events[i] = '0;
                cls_total[i] = '0;
            end
            return r;
        end
        if (m == lbdh_pkg::MODE_NONE || c >= lbdh_pkg::CLASSES)
            return r;
        if (m == lbdh_pkg::MODE_READ)
            b = (sel >= BUCKETS) ? BUCKETS - 1 : sel;
        else
        begin
            w = (c == lbdh_pkg::CLASS_SUSPEND) ? susp_width : idle_width;
            if (w == 0)
                w = 1;
            q = d / w;
            b = bucket_of(q);
            k = c * BUCKETS + b;
            sum = {1'b0, cls_total[c]} + d;
            cls_total[c] = sum[63] ? TOT_SAT : sum[62:0];
            if (cls_events[c] != CNT_SAT)
                cls_events[c]++;
            if (bin_hits[k] == 0)
            begin
                bin_min[k] = d;
                bin_max[k] = d;
            end
            else
            begin
                if (d < bin_min[k])
                    bin_min[k] = d;
                if (d > bin_max[k])
                    bin_max[k] = d;
            end
            if (bin_hits[k] != CNT_SAT)
                bin_hits[k]++;
        end
        k = c * BUCKETS + b;
        r.bidx = b[3:0];
        r.hits = bin_hits[k];
        r.dmin = bin_min[k];
        r.dmax = bin_max[k];
        r.evts = cls_events[c];
        r.total = cls_total[c];
        return r;
    endfunction

    // start stays high after the accepting edge; the next item or drain replaces it
    task automatic send_item(lbdh_pkg::mode_t m, logic [2:0] c, logic [47:0] d,
                             logic [3:0] sel);
        bit offer;
        bit ready;
        offer = 1'b0;
        ready = 1'b0;
        while (!(offer && ready))
        begin
            offer = no_gaps || ($urandom_range(99) >= 22);
            start <= offer;
            mode <= m;
            stat_class <= c;
            duration <= d;
            bucket_select <= sel;
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end
        pending_beats.push_back(histogram_step(m, c, d, sel));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_width(lbdh_pkg::reg_idx_t idx, logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lbdh_pkg::REG_IDLE_WIDTH)
            idle_width = val;
        else
            susp_width = val;
    endtask

    function automatic logic [47:0] rand_dur();
        logic [47:0] d;
        d = 48'({$urandom, $urandom});
        case ($urandom_range(3))
            0: d = d >> $urandom_range(47);
            1: d = d & 48'hFFFF_FFFF;
            2: d = d >> (16 + $urandom_range(31));
            default: ;
        endcase
        return d;
    endfunction

    always @(posedge clk)
    begin
        hist_beat_t got, want;
        if (rst_n && done)
        begin
            got = {bucket_index, bucket_hits, bucket_min, bucket_max, event_count, class_total};
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                beats_checked++;
                if (got.bidx != want.bidx)
                    $display("%0t: bucket_index exp %0d got %0d", $time, want.bidx, got.bidx);
                if (got.hits != want.hits)
                    $display("%0t: bucket_hits exp %0d got %0d", $time, want.hits, got.hits);
                if (got.dmin != want.dmin)
                    $display("%0t: bucket_min exp %0d got %0d", $time, want.dmin, got.dmin);
                if (got.dmax != want.dmax)
                    $display("%0t: bucket_max exp %0d got %0d", $time, want.dmax, got.dmax);
                if (got.evts != want.evts)
                    $display("%0t: event_count exp %0d got %0d", $time, want.evts, got.evts);
                if (got.total != want.total)
                    $display("%0t: class_total exp %0d got %0d", $time, want.total, got.total);
                if (got != want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("log_bucket_duration_histogram_unit_test NOT OK");
            $finish;
        end
    end

    task automatic test_directed;
        send_item(lbdh_pkg::MODE_RECORD, 3'd0, 48'd0, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd0, 48'd0, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd1, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd1, 48'hFFFF_FFFF_FFFF, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd4, 48'd1_000_000_000, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd2, 48'd62500, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd3, 48'd62499, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd5, 48'd1234, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd7, 48'hAAAA_AAAA_AAAA, 4'd0);
        send_item(lbdh_pkg::MODE_READ, 3'd1, 48'd0, 4'd9);
        send_item(lbdh_pkg::MODE_READ, 3'd1, 48'd0, 4'd15);
        send_item(lbdh_pkg::MODE_READ, 3'd0, 48'd0, 4'd0);
        send_item(lbdh_pkg::MODE_READ, 3'd6, 48'h5555_5555_5555, 4'd10);
        send_item(lbdh_pkg::MODE_NONE, 3'd4, 48'd77, 4'd3);
        send_item(lbdh_pkg::MODE_CLEAR, 3'd0, 48'd0, 4'd0);
        send_item(lbdh_pkg::MODE_READ, 3'd1, 48'd0, 4'd9);
    endtask

    task automatic test_zero_width;
        write_width(lbdh_pkg::REG_IDLE_WIDTH, 32'd0);
        write_width(lbdh_pkg::REG_SUSPEND_WIDTH, 32'd0);
        for (int i = 0; i < 48; i++)
            send_item(lbdh_pkg::MODE_RECORD, 3'(i % lbdh_pkg::CLASSES), 48'd1 << i, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd4, 48'd262143, 4'd0);
        send_item(lbdh_pkg::MODE_RECORD, 3'd4, 48'd262144, 4'd0);
        for (int b = 0; b < 16; b++)
            send_item(lbdh_pkg::MODE_READ, 3'd0, 48'd0, 4'(b));
    endtask

    task automatic test_saturation;
        write_width(lbdh_pkg::REG_IDLE_WIDTH, 32'd1);
        for (int i = 0; i < 40; i++)
            send_item(lbdh_pkg::MODE_RECORD, 3'd2, 48'hFFFF_FFFF_FFFF, 4'd0);
        drain();
    endtask

    task automatic test_random(int n, logic [31:0] iw, logic [31:0] sw);
        int pick;
        write_width(lbdh_pkg::REG_IDLE_WIDTH, iw);
        write_width(lbdh_pkg::REG_SUSPEND_WIDTH, sw);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_item(lbdh_pkg::MODE_RECORD, 3'($urandom_range(lbdh_pkg::CLASSES - 1)),
                          rand_dur(), 4'($urandom));
            else if (pick < 90)
                send_item(lbdh_pkg::MODE_READ, 3'($urandom_range(lbdh_pkg::CLASSES - 1)),
                          rand_dur(), 4'($urandom));
            else if (pick < 95)
                send_item(lbdh_pkg::mode_t'(2'($urandom)), 3'($urandom), rand_dur(),
                          4'($urandom));
            else if (pick < 97)
                send_item(lbdh_pkg::MODE_CLEAR, 3'($urandom), rand_dur(), 4'($urandom));
            else
                send_item(lbdh_pkg::MODE_RECORD, 3'(5 + $urandom_range(2)), rand_dur(),
                          4'($urandom));
        end
    endtask

    initial
    begin
        errors = 0;
        beats_checked = 0;
        idle_cycles = 0;
        no_gaps = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        mode = '0;
        stat_class = '0;
        duration = '0;
        bucket_select = '0;
        idle_width = 32'd62500;
        susp_width = 32'd1_000_000_000;
        void'(histogram_step(lbdh_pkg::MODE_CLEAR, 3'd0, 48'd0, 4'd0));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_width();
        test_saturation();
        test_random(500, 32'd62500, 32'd1_000_000_000);
        no_gaps = 1;
        test_random(300, 32'hFFFF_FFFF, 32'd1);
        no_gaps = 0;
        test_random(500, $urandom_range(1, 4096), $urandom);
        test_random(500, $urandom, $urandom_range(1, 65535));
        drain();

        $display("Covered %0d result beats: records, reads, clears, bad modes/classes,",
                 beats_checked);
        $display("zero/extreme widths, bucket clamping and large running totals.");
        if (errors == 0)
            $display("log_bucket_duration_histogram_unit_test OK");
        else
            $display("log_bucket_duration_histogram_unit_test NOT OK");
        $finish;
    end
endmodule
